// ===== rtl/infix_add_sub_paren_evaluator_core_assert.svh =====
// Assertion macros shared by the checker of the infix evaluator core.
// Depends on nothing; included by the checker file only.
`ifndef INFIX_ADD_SUB_PAREN_EVALUATOR_CORE_ASSERT_SVH
`define INFIX_ADD_SUB_PAREN_EVALUATOR_CORE_ASSERT_SVH

// Same-cycle implication, switched off while reset is high.
`define IAPE_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("iape check failed: same-cycle rule");

// Next-cycle implication, switched off while reset is high.
`define IAPE_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("iape check failed: next-cycle rule");

// Next-cycle implication that also holds through reset.
`define IAPE_ASSERT_NEXT_ALWAYS(name, clk, ante, cons) \
   name: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("iape check failed: reset rule");

`endif

// ===== rtl/iape_pkg.sv =====
// Shared types and constants of the infix add/subtract evaluator.
// Used by the front decoder, the command queue and the execution back end.
package iape_pkg;

   // Character codes the decoder recognizes.
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_PLUS   = 8'h2B;
   localparam logic [7:0] CHAR_MINUS  = 8'h2D;
   localparam logic [7:0] CHAR_LPAREN = 8'h28;
   localparam logic [7:0] CHAR_RPAREN = 8'h29;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;

   // Decimal radix for number accumulation.
   localparam logic [31:0] DEC_BASE = 32'd10;

   // Operator stack codes.
   localparam logic OP_PLUS  = 1'b0;
   localparam logic OP_MINUS = 1'b1;

   // Command queue geometry.
   localparam int unsigned CMD_FIFO_DEPTH = 4;
   localparam int unsigned CMD_PTR_W      = $clog2(CMD_FIFO_DEPTH);
   localparam int unsigned CMD_CNT_W      = $clog2(CMD_FIFO_DEPTH + 1);

   // Stack work that one character asks of the back end, in execution order:
   // operand push (with optional reduce), operator push, second reduce, emit.
   typedef struct packed {
      logic        push;
      logic [31:0] value;
      logic        red1;
      logic        op_push;
      logic        op_minus;
      logic        red2;
      logic        emit;
   } cmd_type;

endpackage

// ===== rtl/iape_front.sv =====
// Front end: parses characters, accumulates numbers and issues stack commands.
// Depends on iape_pkg for character codes and the command type.
module iape_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   input  logic [7:0]         req_char_code,
   input  logic               req_is_last,
   input  logic               fifo_full,
   output logic               req_full,
   output logic               cmd_valid,
   output iape_pkg::cmd_type  cmd
);

   typedef enum logic [1:0] {
      MODE_BEGIN,
      MODE_NUMBER,
      MODE_OPERATOR
   } mode_type;

   mode_type    mode_ff, mode_in;
   logic [31:0] acc_ff, acc_in;
   logic        pending_ff, pending_in;

   logic        accept;
   logic        is_digit;
   logic [7:0]  digit_off;
   logic [31:0] acc_digit;
   mode_type    eff_mode;
   logic        has_work;

   // A beat is taken whenever the command queue has room.
   assign req_full = fifo_full;
   assign accept   = req_push && !fifo_full;

   assign is_digit  = (req_char_code >= iape_pkg::CHAR_ZERO) &&
                      (req_char_code <= iape_pkg::CHAR_NINE);
   assign digit_off = req_char_code - iape_pkg::CHAR_ZERO;
   assign acc_digit = (acc_ff * iape_pkg::DEC_BASE) + {28'd0, digit_off[3:0]};

   // Parse one character and build the command for the back end.
   always_comb begin
      mode_in    = mode_ff;
      acc_in     = acc_ff;
      pending_in = pending_ff;
      cmd        = '0;

      // The begin mode (and the unused code) resolves at once from the character.
      unique case (mode_ff)
         MODE_NUMBER:   eff_mode = MODE_NUMBER;
         MODE_OPERATOR: eff_mode = MODE_OPERATOR;
         default:       eff_mode = is_digit ? MODE_NUMBER : MODE_OPERATOR;
      endcase

      if (req_char_code != iape_pkg::CHAR_SPACE) begin
         if (is_digit) begin
            mode_in = MODE_NUMBER;
            acc_in  = acc_digit;
         end else begin
            mode_in = MODE_OPERATOR;
            // A non-digit closes a number under way.
            if (eff_mode == MODE_NUMBER) begin
               cmd.push  = 1'b1;
               cmd.value = acc_ff;
               cmd.red1  = pending_ff;
               acc_in    = '0;
            end
            unique case (req_char_code)
               iape_pkg::CHAR_PLUS: begin
                  cmd.op_push  = 1'b1;
                  cmd.op_minus = iape_pkg::OP_PLUS;
                  pending_in   = 1'b1;
               end
               iape_pkg::CHAR_MINUS: begin
                  cmd.op_push  = 1'b1;
                  cmd.op_minus = iape_pkg::OP_MINUS;
                  pending_in   = 1'b1;
               end
               iape_pkg::CHAR_LPAREN: begin
                  pending_in = 1'b0;
                  mode_in    = MODE_NUMBER;
               end
               iape_pkg::CHAR_RPAREN: begin
                  cmd.red2 = 1'b1;
               end
               default: begin
               end
            endcase
         end
      end

      // The last character flushes a nonzero number and asks for the result.
      if (req_is_last) begin
         if (acc_in != '0) begin
            cmd.push  = 1'b1;
            cmd.value = acc_in;
            cmd.red1  = 1'b1;
         end
         cmd.emit   = 1'b1;
         mode_in    = MODE_BEGIN;
         acc_in     = '0;
         pending_in = 1'b0;
      end
   end

   assign has_work  = cmd.push | cmd.op_push | cmd.red2 | cmd.emit;
   assign cmd_valid = accept && has_work;

   // Parser state.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_BEGIN;
         acc_ff     <= '0;
         pending_ff <= 1'b0;
      end else if (accept) begin
         mode_ff    <= mode_in;
         acc_ff     <= acc_in;
         pending_ff <= pending_in;
      end
   end

endmodule

// ===== rtl/iape_cmd_fifo.sv =====
// Short command queue between the front decoder and the back end.
// Depends on iape_pkg for the command type and queue geometry.
module iape_cmd_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  iape_pkg::cmd_type  wr_cmd,
   output logic               full,
   input  logic               rd_en,
   output logic               head_valid,
   output iape_pkg::cmd_type  head_cmd
);

   iape_pkg::cmd_type                      entry_ff [iape_pkg::CMD_FIFO_DEPTH];
   logic [iape_pkg::CMD_PTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [iape_pkg::CMD_PTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [iape_pkg::CMD_CNT_W-1:0]         count_ff, count_in;

   assign full       = (count_ff == iape_pkg::CMD_CNT_W'(iape_pkg::CMD_FIFO_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (!wr_en && rd_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

endmodule

// ===== rtl/iape_back.sv =====
// Back end: operand and operator stacks with cached tops, adder and result register.
// Depends on iape_pkg for the command type and operator codes.
module iape_back #(
   parameter int unsigned STACK_DEPTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_valid,
   input  iape_pkg::cmd_type  cmd,
   output logic               cmd_pop,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic signed [31:0] rsp_value,
   output logic               rsp_error
);

   localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
   localparam int unsigned AW = $clog2(STACK_DEPTH);

   // Operand stack: two cached tops plus memory for deeper entries.
   logic [31:0]   top0_ff, top0_in;
   logic [31:0]   top1_ff, top1_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [31:0]   omem [STACK_DEPTH];
   logic [31:0]   ord_ff;
   logic          owe;
   logic [AW-1:0] owaddr;
   logic [AW-1:0] ordaddr;
   logic [CW-1:0] ord_cnt;

   // Operator stack: cached top plus memory for deeper entries.
   logic          optop_ff, optop_in;
   logic [CW-1:0] opc_ff, opc_in;
   logic          opmem [STACK_DEPTH];
   logic          oprd_ff;
   logic          opwe;
   logic [AW-1:0] opwaddr;
   logic [AW-1:0] oprdaddr;
   logic [CW-1:0] oprd_cnt;

   logic          ovf_ff, ovf_in;
   logic          phase_ff, phase_in;

   logic          out_valid_ff, out_valid_in;
   logic [31:0]   out_value_ff, out_value_in;
   logic          out_error_ff, out_error_in;

   logic          has_a, has_b, do_a, do_b, fin, out_ready, go, emit_now;
   logic          can_reduce, sel_fused, pop_op, push_op;
   logic [31:0]   alu_lhs, alu_rhs, alu_out;

   // Phase sequencing: part A is the operand and operator push, part B the
   // closing-parenthesis reduce.
   assign has_a     = cmd.push | cmd.op_push;
   assign has_b     = cmd.red2;
   assign do_a      = !phase_ff && has_a;
   assign do_b      = has_b && (phase_ff || !has_a);
   assign fin       = !(do_a && has_b);
   assign out_ready = !out_valid_ff || rsp_pop;
   assign go        = cmd_valid && (!(fin && cmd.emit) || out_ready);
   assign emit_now  = go && fin && cmd.emit;
   assign cmd_pop   = go && fin;

   assign can_reduce = (cnt_ff >= CW'(2)) && (opc_ff != '0);

   // A fused push-and-reduce applies the top operator to the top and the incoming value straight away.
   assign sel_fused = do_a && cmd.push && cmd.red1 && (cnt_ff != CW'(STACK_DEPTH)) &&
                      (cnt_ff != '0) && (opc_ff != '0);
   assign alu_lhs   = sel_fused ? top0_ff : top1_ff;
   assign alu_rhs   = sel_fused ? cmd.value : top0_ff;
   assign alu_out   = (optop_ff == iape_pkg::OP_MINUS) ? (alu_lhs - alu_rhs)
                                                        : (alu_lhs + alu_rhs);

   // Next state of both stacks for the step taken this cycle.
   always_comb begin
      top0_in      = top0_ff;
      top1_in      = top1_ff;
      cnt_in       = cnt_ff;
      optop_in     = optop_ff;
      opc_in       = opc_ff;
      ovf_in       = ovf_ff;
      phase_in     = phase_ff;
      owe          = 1'b0;
      owaddr       = AW'(cnt_ff - CW'(2));
      opwe         = 1'b0;
      opwaddr      = AW'(opc_ff - CW'(1));
      pop_op       = 1'b0;
      push_op      = 1'b0;
      out_value_in = out_value_ff;
      out_error_in = out_error_ff;

      if (go) begin
         phase_in = !fin;
         if (do_a) begin
            if (cmd.push) begin
               if (cnt_ff == CW'(STACK_DEPTH)) begin
                  // Push refused; a requested reduce still runs on the stack.
                  ovf_in = 1'b1;
                  if (cmd.red1 && can_reduce) begin
                     top0_in = alu_out;
                     top1_in = ord_ff;
                     cnt_in  = cnt_ff - CW'(1);
                     pop_op  = 1'b1;
                  end
               end else if (sel_fused) begin
                  top0_in = alu_out;
                  pop_op  = 1'b1;
               end else begin
                  top1_in = top0_ff;
                  top0_in = cmd.value;
                  cnt_in  = cnt_ff + CW'(1);
                  owe     = (cnt_ff >= CW'(2));
               end
            end
            push_op = cmd.op_push;
         end else if (do_b) begin
            if (can_reduce) begin
               top0_in = alu_out;
               top1_in = ord_ff;
               cnt_in  = cnt_ff - CW'(1);
               pop_op  = 1'b1;
            end
         end

         // Operator stack update.
         if (push_op && pop_op) begin
            optop_in = cmd.op_minus;
         end else if (pop_op) begin
            optop_in = oprd_ff;
            opc_in   = opc_ff - CW'(1);
         end else if (push_op) begin
            if (opc_ff == CW'(STACK_DEPTH)) begin
               ovf_in = 1'b1;
            end else begin
               opwe     = (opc_ff != '0);
               optop_in = cmd.op_minus;
               opc_in   = opc_ff + CW'(1);
            end
         end

         // Result capture, then the stacks empty for the next expression.
         if (emit_now) begin
            out_value_in = (cnt_in != '0) ? top0_in : '0;
            out_error_in = ovf_in;
            cnt_in       = '0;
            opc_in       = '0;
            ovf_in       = 1'b0;
         end
      end
   end

   // The prefetch registers always hold the entry just below the cached tops.
   assign ord_cnt  = cnt_in - CW'(3);
   assign ordaddr  = ord_cnt[AW-1:0];
   assign oprd_cnt = opc_in - CW'(2);
   assign oprdaddr = oprd_cnt[AW-1:0];

   // Operand memory with a registered, forwarded read.
   always_ff @(posedge clock) begin
      if (owe) begin
         omem[owaddr] <= top1_ff;
      end
      if (owe && (owaddr == ordaddr)) begin
         ord_ff <= top1_ff;
      end else begin
         ord_ff <= omem[ordaddr];
      end
   end

   // Operator memory with a registered, forwarded read.
   always_ff @(posedge clock) begin
      if (opwe) begin
         opmem[opwaddr] <= optop_ff;
      end
      if (opwe && (opwaddr == oprdaddr)) begin
         oprd_ff <= optop_ff;
      end else begin
         oprd_ff <= opmem[oprdaddr];
      end
   end

   // Output register valid flag.
   always_comb begin
      out_valid_in = out_valid_ff;
      if (emit_now) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         opc_ff       <= '0;
         ovf_ff       <= 1'b0;
         phase_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         opc_ff       <= opc_in;
         ovf_ff       <= ovf_in;
         phase_ff     <= phase_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Cached tops and result payload.
   always_ff @(posedge clock) begin
      top0_ff      <= top0_in;
      top1_ff      <= top1_in;
      optop_ff     <= optop_in;
      out_value_ff <= out_value_in;
      out_error_ff <= out_error_in;
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_value = $signed(out_value_ff);
   assign rsp_error = out_error_ff;

endmodule

// ===== rtl/infix_add_sub_paren_evaluator_core.sv =====
// Infix add/subtract evaluator with parentheses, one character per beat.
// Built from iape_front, iape_cmd_fifo and iape_back; uses iape_pkg.
//
// Usage: characters of an expression enter on the request queue port
// (req_push / req_full) with req_is_last marking the final one. One result
// per expression leaves on the response queue port (rsp_empty / rsp_pop) as
// rsp_value (32-bit two's complement, wrapping) and rsp_error (a stack ran
// out of room during the expression).
// The front takes one beat per cycle while the four-entry command queue has
// room; digits and spaces cost the back end nothing. The back end runs the push
// part of a command and then, when a ')' also closes a number, its reduce part
// as a separate step, so the sustained rate is one character per cycle for
// typical input and the queue absorbs the extra step of a closing parenthesis.
// With nothing queued ahead, the last character's command passes through the
// queue to the back end, which loads the result register. The result register
// holds one answer; while it is not popped the back end keeps working until it
// needs to emit again, then the queue fills and req_full rises.
// Reset clears the parser, the queue, both stack counts and the result valid
// flag; stack memories are not cleared.
module infix_add_sub_paren_evaluator_core #(
   parameter int unsigned STACK_DEPTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [7:0]         req_char_code,
   input  logic               req_is_last,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic signed [31:0] rsp_value,
   output logic               rsp_error
);

   iape_pkg::cmd_type front_cmd;
   iape_pkg::cmd_type head_cmd;
   logic              front_valid;
   logic              fifo_full;
   logic              head_valid;
   logic              head_pop;

   // Character parser.
   iape_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_char_code (req_char_code),
      .req_is_last   (req_is_last),
      .fifo_full     (fifo_full),
      .req_full      (req_full),
      .cmd_valid     (front_valid),
      .cmd           (front_cmd)
   );

   // Decoupling queue.
   iape_cmd_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (front_valid),
      .wr_cmd     (front_cmd),
      .full       (fifo_full),
      .rd_en      (head_pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   // Stack execution and result register.
   iape_back #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (head_valid),
      .cmd       (head_cmd),
      .cmd_pop   (head_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_value (rsp_value),
      .rsp_error (rsp_error)
   );

endmodule

// ===== rtl/iape_checker.sv =====
// Port-level checks of the infix evaluator core, attached by a bind.
// Depends on infix_add_sub_paren_evaluator_core_assert.svh for the macros.
`include "infix_add_sub_paren_evaluator_core_assert.svh"

module iape_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_push,
   input logic        req_full,
   input logic        req_is_last,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [31:0] rsp_value,
   input logic        rsp_error
);

   logic [3:0] outstanding_ff, outstanding_in;
   logic       last_beat;
   logic       rsp_beat;

   assign last_beat = req_push && !req_full && req_is_last;
   assign rsp_beat  = rsp_pop && !rsp_empty;

   // Expressions ended on the request side and not yet answered.
   always_comb begin
      outstanding_in = outstanding_ff;
      if (last_beat && !rsp_beat) begin
         outstanding_in = outstanding_ff + 4'd1;
      end else if (!last_beat && rsp_beat) begin
         outstanding_in = outstanding_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_in;
      end
   end

   // Reset leaves both queues empty.
   `IAPE_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, rsp_empty && !req_full)

   // A stalled result holds.
   `IAPE_ASSERT_NEXT(a_rsp_hold, clock, reset, !rsp_empty && !rsp_pop,
                     !rsp_empty && $stable(rsp_value) && $stable(rsp_error))

   // A result only appears for an expression whose last character went in.
   `IAPE_ASSERT_IMP(a_rsp_has_cause, clock, reset, !rsp_empty, outstanding_ff != 4'd0)

endmodule

bind infix_add_sub_paren_evaluator_core iape_checker u_iape_checker (.*);

// ===== verif/infix_add_sub_paren_evaluator_checker.sv =====
// Result checker for the infix add/subtract evaluator core.
// Watches the request and response queue ports, predicts each result and compares it.
// Depends on iape_pkg for the character codes and operator codes.
module infix_add_sub_paren_evaluator_checker #(
   parameter int unsigned STACK_DEPTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   input  logic               req_full,
   input  logic [7:0]         req_char_code,
   input  logic               req_is_last,
   input  logic               rsp_empty,
   input  logic               rsp_pop,
   input  logic signed [31:0] rsp_value,
   input  logic               rsp_error,
   output int                 mismatch_count,
   output int                 pending_results
);

   typedef enum logic [1:0] {SCAN_START, SCAN_DIGITS, SCAN_OPER} scan_state_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic               error;
   } eval_result_type;

   // Shadow copy of the evaluator state; the top of each stack is the back of its queue.
   logic [31:0]     operands[$];
   logic            operators[$];
   logic [31:0]     number_acc;
   scan_state_type  scan_state;
   logic            reduce_armed;
   logic            stack_overflowed;

   // Results predicted but not yet seen on the response port.
   eval_result_type expected_results[$];
   int              errors = 0;

   // Return the parser to the state it has between expressions.
   function automatic void clear_expression();
      operands.delete();
      operators.delete();
      number_acc       = '0;
      scan_state       = SCAN_START;
      reduce_armed     = 1'b0;
      stack_overflowed = 1'b0;
   endfunction

   function automatic void push_operand_value(input logic [31:0] v);
      if (operands.size() < STACK_DEPTH) begin
         operands.push_back(v);
      end else begin
         stack_overflowed = 1'b1;
      end
   endfunction

   function automatic void push_operator_code(input logic op);
      if (operators.size() < STACK_DEPTH) begin
         operators.push_back(op);
      end else begin
         stack_overflowed = 1'b1;
      end
   endfunction

   // Combine the two top operands with the top operator; no-op when either stack is short.
   function automatic void apply_top_operator();
      logic [31:0] lhs;
      logic [31:0] rhs;
      logic        op;
      if (operands.size() < 2 || operators.size() == 0) return;
      rhs = operands.pop_back();
      lhs = operands.pop_back();
      op  = operators.pop_back();
      if (op == iape_pkg::OP_MINUS) begin
         operands.push_back(lhs - rhs);
      end else begin
         operands.push_back(lhs + rhs);
      end
   endfunction

   // One non-space character through the parser. A character that ends a number
   // is handled again in operator mode, so the loop may take a few passes.
   function automatic void scan_char(input logic [7:0] c);
      logic is_digit;
      int   pass;
      is_digit = (c >= iape_pkg::CHAR_ZERO && c <= iape_pkg::CHAR_NINE);
      for (pass = 0; pass < 4; pass++) begin
         case (scan_state)
            SCAN_DIGITS: begin
               if (is_digit) begin
                  number_acc = number_acc * iape_pkg::DEC_BASE +
                               {24'b0, c - iape_pkg::CHAR_ZERO};
                  return;
               end
               push_operand_value(number_acc);
               if (reduce_armed) apply_top_operator();
               number_acc = '0;
               scan_state = SCAN_OPER;
            end
            SCAN_OPER: begin
               if (is_digit) begin
                  scan_state = SCAN_DIGITS;
               end else begin
                  if (c == iape_pkg::CHAR_PLUS || c == iape_pkg::CHAR_MINUS) begin
                     push_operator_code(c == iape_pkg::CHAR_MINUS ? iape_pkg::OP_MINUS
                                                                  : iape_pkg::OP_PLUS);
                     reduce_armed = 1'b1;
                  end else if (c == iape_pkg::CHAR_LPAREN) begin
                     reduce_armed = 1'b0;
                     scan_state   = SCAN_DIGITS;
                  end else if (c == iape_pkg::CHAR_RPAREN) begin
                     apply_top_operator();
                  end
                  return;
               end
            end
            default: begin
               scan_state = is_digit ? SCAN_DIGITS : SCAN_OPER;
            end
         endcase
      end
   endfunction

   // Advance the prediction by one accepted request beat.
   function automatic void take_char(input logic [7:0] c, input logic last);
      eval_result_type result;
      if (c != iape_pkg::CHAR_SPACE) scan_char(c);
      if (!last) return;
      // A pending number of zero is dropped rather than pushed.
      if (number_acc != '0) begin
         push_operand_value(number_acc);
         apply_top_operator();
      end
      result.value = (operands.size() > 0) ? operands[operands.size() - 1] : '0;
      result.error = stack_overflowed;
      expected_results.push_back(result);
      clear_expression();
   endfunction

   // Compare response beats against the oldest prediction, then absorb request beats.
   always @(posedge clock) begin
      eval_result_type want;
      if (reset) begin
         clear_expression();
         expected_results.delete();
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_results.size() == 0) begin
               errors++;
               $error("result beat with no expression outstanding: rsp_value %0d rsp_error %0b",
                      rsp_value, rsp_error);
            end else begin
               want = expected_results.pop_front();
               if (rsp_value !== want.value) begin
                  errors++;
                  $error("rsp_value mismatch: expected %0d, actual %0d", want.value, rsp_value);
               end
               if (rsp_error !== want.error) begin
                  errors++;
                  $error("rsp_error mismatch: expected %0b, actual %0b", want.error, rsp_error);
               end
            end
         end
         if (req_push && !req_full) take_char(req_char_code, req_is_last);
      end
      mismatch_count  <= errors;
      pending_results <= expected_results.size();
   end

endmodule

// ===== verif/infix_add_sub_paren_evaluator_core_test.sv =====
// Testbench top for the infix add/subtract evaluator core.
// Drives expressions one character per beat and gives the verdict; depends on iape_pkg,
// the core and infix_add_sub_paren_evaluator_checker.
module infix_add_sub_paren_evaluator_core_test;

   localparam int unsigned DEPTH         = 32;
   localparam int unsigned CYCLE_LIMIT   = 400000;
   localparam int          PHASE_CHARS   = 250;
   localparam int          HOLD_CYCLES   = 400;
   localparam int          DRAIN_CYCLES  = 20;

   logic               clock;
   logic               reset;
   logic               req_push;
   logic               req_full;
   logic [7:0]         req_char_code;
   logic               req_is_last;
   logic               rsp_empty;
   logic               rsp_pop;
   logic signed [31:0] rsp_value;
   logic               rsp_error;
   int                 mismatch_count;
   int                 pending_results;

   logic [7:0]  expr_chars[$];
   int          tx_idle_pct;
   int          rx_stall_pct;
   bit          hold_request;
   int          chars_sent;
   int unsigned cycle_count = 0;

   infix_add_sub_paren_evaluator_core #(.STACK_DEPTH(DEPTH)) u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_char_code (req_char_code),
      .req_is_last   (req_is_last),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_value     (rsp_value),
      .rsp_error     (rsp_error)
   );

   infix_add_sub_paren_evaluator_checker #(.STACK_DEPTH(DEPTH)) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_char_code   (req_char_code),
      .req_is_last     (req_is_last),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_value       (rsp_value),
      .rsp_error       (rsp_error),
      .mismatch_count  (mismatch_count),
      .pending_results (pending_results)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Response side: random stalls, plus one long hold-off on request.
   initial begin
      int hold_left;
      bit hold_taken;
      hold_left  = 0;
      hold_taken = 1'b0;
      rsp_pop    = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(0, 99) >= rx_stall_pct);
         end
      end
   end

   // Append a character, now and then with a space in front of it.
   function automatic void add_char(input logic [7:0] c);
      if ($urandom_range(0, 9) == 0) expr_chars.push_back(iape_pkg::CHAR_SPACE);
      expr_chars.push_back(c);
   endfunction

   function automatic void load_text(input string s);
      int i;
      expr_chars.delete();
      for (i = 0; i < s.len(); i++) expr_chars.push_back(s[i]);
   endfunction

   // A balanced expression with random numbers, operators and nesting. A deep one
   // nests far enough to run both stacks out of room.
   function automatic void build_wellformed();
      int depth;
      int depth_cap;
      int term_goal;
      int terms;
      int digits;
      int i;
      bit want_operand;
      bit deep;
      depth        = 0;
      terms        = 0;
      want_operand = 1'b1;
      deep         = ($urandom_range(0, 19) == 0);
      depth_cap    = deep ? 40 : 4;
      term_goal    = deep ? 45 : $urandom_range(1, 8);
      expr_chars.delete();
      while (1) begin
         if (want_operand) begin
            if (depth < depth_cap && terms < term_goal &&
                (deep ? $urandom_range(0, 3) != 0 : $urandom_range(0, 3) == 0)) begin
               add_char(iape_pkg::CHAR_LPAREN);
               depth++;
               if ($urandom_range(0, 2) == 0) add_char(iape_pkg::CHAR_MINUS);
            end else begin
               // Mostly short numbers; a long one wraps the 32-bit accumulator.
               digits = ($urandom_range(0, 15) == 0) ? 12 : $urandom_range(1, 3);
               for (i = 0; i < digits; i++)
                  add_char(8'(iape_pkg::CHAR_ZERO + $urandom_range(0, 9)));
               terms++;
               want_operand = 1'b0;
            end
         end else begin
            if (depth == 0 && terms >= term_goal) break;
            if (depth > 0 && (terms >= term_goal || $urandom_range(0, 2) == 0)) begin
               add_char(iape_pkg::CHAR_RPAREN);
               depth--;
            end else begin
               add_char($urandom_range(0, 1) ? iape_pkg::CHAR_MINUS : iape_pkg::CHAR_PLUS);
               want_operand = 1'b1;
            end
         end
      end
      if ($urandom_range(0, 7) == 0) expr_chars.push_back(iape_pkg::CHAR_SPACE);
   endfunction

   // Broken input: a run of operators that fills the operator stack, or a mix of
   // arbitrary bytes and syntax characters.
   function automatic void build_noise();
      int count;
      int i;
      expr_chars.delete();
      if ($urandom_range(0, 3) == 0) begin
         count = $urandom_range(DEPTH + 1, DEPTH + 8);
         for (i = 0; i < count; i++)
            expr_chars.push_back($urandom_range(0, 1) ? iape_pkg::CHAR_MINUS
                                                      : iape_pkg::CHAR_PLUS);
      end else begin
         count = $urandom_range(1, 20);
         for (i = 0; i < count; i++) begin
            if ($urandom_range(0, 1)) begin
               expr_chars.push_back(8'($urandom_range(0, 255)));
            end else begin
               case ($urandom_range(0, 5))
                  0:       expr_chars.push_back(iape_pkg::CHAR_PLUS);
                  1:       expr_chars.push_back(iape_pkg::CHAR_MINUS);
                  2:       expr_chars.push_back(iape_pkg::CHAR_LPAREN);
                  3:       expr_chars.push_back(iape_pkg::CHAR_RPAREN);
                  4:       expr_chars.push_back(iape_pkg::CHAR_SPACE);
                  default: expr_chars.push_back(8'(iape_pkg::CHAR_ZERO +
                                                    $urandom_range(0, 9)));
               endcase
            end
         end
      end
   endfunction

   // One request beat, after an optional random gap. req_push stays high between
   // back-to-back beats.
   task automatic send_char(input logic [7:0] c, input logic last);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push      <= 1'b1;
      req_char_code <= c;
      req_is_last   <= last;
      @(posedge clock);
      while (req_full) @(posedge clock);
      chars_sent++;
   endtask

   task automatic send_expression();
      int i;
      for (i = 0; i < expr_chars.size(); i++)
         send_char(expr_chars[i], i == expr_chars.size() - 1);
   endtask

   // Lower the request and wait until every predicted result has been popped.
   task automatic wait_for_drain();
      req_push <= 1'b0;
      @(posedge clock);
      wait (pending_results == 0);
   endtask

   initial begin
      int phase;
      int phase_start;
      reset         = 1'b1;
      req_push      = 1'b0;
      req_char_code = '0;
      req_is_last   = 1'b0;
      hold_request  = 1'b0;
      tx_idle_pct   = 0;
      rx_stall_pct  = 0;
      chars_sent    = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: unary minus in parentheses, a trailing space on the last beat,
      // an empty expression, stray bytes, and a wrapping sum.
      load_text("9-(-8)");
      send_expression();
      load_text("1+2 ");
      send_expression();
      load_text(" ");
      send_expression();
      load_text("a7");
      expr_chars.push_back(8'hFF);
      send_expression();
      load_text("4294967295+1");
      send_expression();
      wait_for_drain();

      // Random expressions in phases of different idle and stall pressure.
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               tx_idle_pct  = 0;
               rx_stall_pct = 0;
            end
            1: begin
               tx_idle_pct  = 61;
               rx_stall_pct = 0;
            end
            2: begin
               tx_idle_pct  = 0;
               rx_stall_pct = 61;
               hold_request = 1'b1;
            end
            default: begin
               tx_idle_pct  = 37;
               rx_stall_pct = 37;
            end
         endcase
         phase_start = chars_sent;
         while (chars_sent < phase_start + PHASE_CHARS) begin
            if ($urandom_range(0, 3) != 0) build_wellformed();
            else build_noise();
            send_expression();
         end
         wait_for_drain();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_results == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
